FILE: rtl/key_scanner_long_press_defines.svh
// ---------------------------------------------------------------------------
// key_scanner_long_press_defines: assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef KEY_SCANNER_LONG_PRESS_DEFINES_SVH
`define KEY_SCANNER_LONG_PRESS_DEFINES_SVH

// same-cycle implication
`define KSLP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kslp assertion failed");

// next-cycle implication
`define KSLP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kslp assertion failed");

`endif

FILE: rtl/kslp_pkg.sv
// ---------------------------------------------------------------------------
// kslp_pkg: key scanner shared definitions
// Item type, key codes, register indexes and reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kslp_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int DIV_W      = 8;
	localparam int HOLD_W     = 16;
	localparam int CODE_W     = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 1'd1;

	localparam logic [DIV_W-1:0]  SCAN_PERIOD_RST = 8'd20;
	localparam logic [HOLD_W-1:0] LONG_TICKS_RST  = 16'd1000;
	localparam logic [HOLD_W-1:0] HOLD_MAX        = 16'hFFFF;

	// request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// key codes
	localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
	localparam logic [CODE_W-1:0] CODE_KEY1  = 3'd1;
	localparam logic [CODE_W-1:0] CODE_KEY2  = 3'd2;
	localparam logic [CODE_W-1:0] CODE_SHORT = 3'd3;
	localparam logic [CODE_W-1:0] CODE_LONG  = 3'd4;

	typedef struct packed {
		logic req_type;
		logic key1_level;
		logic key2_level;
		logic key3_level;
	} item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
		logic                  we;
	} cfg_wr_t;

endpackage

FILE: rtl/key_scanner_long_press.sv
// ---------------------------------------------------------------------------
// key_scanner_long_press: three-key scanner with key-3 long press
// Top level: input register, scan engine and result register.
// ---------------------------------------------------------------------------
// Takes one request per clock: a tick with the three active-low key levels,
// or a read that returns and clears the last key released (0 none, 1 key1,
// 2 key2, 3 key3 short, 4 key3 long; ticks return 0). Every request gives
// exactly one result, registered first in the input register and then in the
// result register, and a new request is taken every cycle while the result
// side keeps up; a stalled result holds one more request in the input
// register. scan_period (index 0) sets the ticks between samples and
// long_press_ticks (index 1) the hold count key 3 must exceed for a long
// press; write them only while the block is idle.
`timescale 1ns / 1ps

module key_scanner_long_press
	import kslp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic                  key1_level,
	input  logic                  key2_level,
	input  logic                  key3_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CODE_W-1:0]     key_event,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	item_t   in_item;
	item_t   item_s1;
	logic    item_valid_s1;
	logic    take;
	cfg_wr_t cfg_wr;

	assign in_item.req_type   = req_type;
	assign in_item.key1_level = key1_level;
	assign in_item.key2_level = key2_level;
	assign in_item.key3_level = key3_level;

	assign cfg_wr.we    = cfg_we;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	kslp_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.take          (take),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	kslp_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.take          (take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_event     (key_event)
	);

endmodule

FILE: rtl/kslp_in_reg.sv
// ---------------------------------------------------------------------------
// kslp_in_reg: input register
// Captures one request per transfer and holds it until the engine takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_scanner_long_press_defines.svh"

module kslp_in_reg
	import kslp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  take,
	output logic  item_valid_s1,
	output item_t item_s1
);

	// stage is free when empty or being drained this cycle
	assign in_ready = !item_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	`KSLP_ASSERT_IMP(a_full_when_blocked, !in_ready, item_valid_s1)
	`KSLP_ASSERT_IMP(a_take_needs_item, take, item_valid_s1)

endmodule

FILE: rtl/kslp_engine.sv
// ---------------------------------------------------------------------------
// kslp_engine: scan state and result register
// Applies one tick or read per cycle, unless the result stalls, to the scan state and registers the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_scanner_long_press_defines.svh"

module kslp_engine
	import kslp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg_wr,
	input  logic              item_valid_s1,
	input  item_t             item_s1,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CODE_W-1:0] key_event
);

	logic [DIV_W-1:0]  scan_period_q;
	logic [HOLD_W-1:0] long_ticks_q;
	logic [DIV_W-1:0]  div_q;
	logic [HOLD_W-1:0] hold_q;
	logic [CODE_W-1:0] prev_code_q;
	logic [CODE_W-1:0] cur_code_q;
	logic [CODE_W-1:0] latched_q;

	logic              is_read;
	logic              k1, k2, k3;
	logic [HOLD_W-1:0] hold_nx;
	logic [DIV_W-1:0]  div_inc;
	logic              sample;
	logic [CODE_W-1:0] code_nx;

	// result register frees up when empty or being read out
	assign take    = item_valid_s1 && (!out_valid || out_ready);
	assign is_read = (item_s1.req_type == REQ_READ);
	assign k1      = !item_s1.key1_level;
	assign k2      = !item_s1.key2_level;
	assign k3      = !item_s1.key3_level;

	// hold counter first, saturating
	always_comb begin
		if (!k3) begin
			hold_nx = '0;
		end else if (hold_q == HOLD_MAX) begin
			hold_nx = hold_q;
		end else begin
			hold_nx = hold_q + HOLD_W'(1);
		end
	end

	// scan divider, wraps at 8 bits like the counter it models
	assign div_inc = div_q + DIV_W'(1);
	assign sample  = (div_inc >= scan_period_q);

	// priority sample using the updated hold count
	always_comb begin
		if (k1) begin
			code_nx = CODE_KEY1;
		end else if (k2) begin
			code_nx = CODE_KEY2;
		end else if (k3 && (hold_nx > long_ticks_q)) begin
			code_nx = CODE_LONG;
		end else if (k3) begin
			code_nx = CODE_SHORT;
		end else begin
			code_nx = CODE_NONE;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
			long_ticks_q  <= LONG_TICKS_RST;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				CFG_SCAN_PERIOD: scan_period_q <= cfg_wr.data[DIV_W-1:0];
				CFG_LONG_TICKS:  long_ticks_q  <= cfg_wr.data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q       <= '0;
			hold_q      <= '0;
			prev_code_q <= CODE_NONE;
			cur_code_q  <= CODE_NONE;
			latched_q   <= CODE_NONE;
		end else if (take) begin
			if (is_read) begin
				latched_q <= CODE_NONE;
			end else begin
				hold_q <= hold_nx;
				if (sample) begin
					div_q       <= '0;
					prev_code_q <= cur_code_q;
					cur_code_q  <= code_nx;
					// release: nonzero code falls to zero
					if ((cur_code_q != CODE_NONE) && (code_nx == CODE_NONE)) begin
						latched_q <= cur_code_q;
					end
				end else begin
					div_q <= div_inc;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_event <= is_read ? latched_q : CODE_NONE;
		end
	end

	`KSLP_ASSERT_NXT(a_read_clears, take && is_read, latched_q == CODE_NONE)
	`KSLP_ASSERT_NXT(a_release_clears_hold, take && !is_read && !k3, hold_q == '0)
	`KSLP_ASSERT_IMP(a_code_range, 1'b1,
		(latched_q <= CODE_LONG) && (prev_code_q <= CODE_LONG) && (cur_code_q <= CODE_LONG))

endmodule

FILE: verif/key_event_checker.sv
// ---------------------------------------------------------------------------
// key_event_checker: scoreboard for the three-key scanner
// Watches the request, result and register ports, predicts the key event of
// every request and compares it with the result, oldest first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_event_checker
	import kslp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  req_type,
	input  logic                  key1_level,
	input  logic                  key2_level,
	input  logic                  key3_level,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [CODE_W-1:0]     key_event,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	// shadow copy of the registers and the scan state
	logic [DIV_W-1:0]  period_q;
	logic [HOLD_W-1:0] long_q;
	logic [DIV_W-1:0]  tick_cnt;
	logic [HOLD_W-1:0] hold_cnt;
	logic [CODE_W-1:0] prev_code;
	logic [CODE_W-1:0] cur_code;
	logic [CODE_W-1:0] event_q;

	logic [CODE_W-1:0] expected_events[$];
	int                errors;

	// advance the shadow scanner by one request, return its key event
	function automatic logic [CODE_W-1:0] scan_keys(item_t req);
		logic                  k1;
		logic                  k2;
		logic                  k3;
		logic [CODE_W-1:0]     result;
		k1 = (req.key1_level == 1'b0);
		k2 = (req.key2_level == 1'b0);
		k3 = (req.key3_level == 1'b0);
		if (req.req_type == REQ_READ) begin
			result  = event_q;
			event_q = CODE_NONE;
			return result;
		end
		// key 3 hold count, saturating
		if (k3) begin
			if (hold_cnt != HOLD_MAX)
				hold_cnt = hold_cnt + 1'b1;
		end else begin
			hold_cnt = '0;
		end
		// divider; a zero period samples on every tick
		tick_cnt = tick_cnt + 1'b1;
		if (tick_cnt >= period_q) begin
			tick_cnt  = '0;
			prev_code = cur_code;
			if (k1)
				cur_code = CODE_KEY1;
			else if (k2)
				cur_code = CODE_KEY2;
			else if (k3 && hold_cnt > long_q)
				cur_code = CODE_LONG;
			else if (k3)
				cur_code = CODE_SHORT;
			else
				cur_code = CODE_NONE;
			// release: latch the code that was held, overwriting an unread one
			if (prev_code != CODE_NONE && cur_code == CODE_NONE)
				event_q = prev_code;
		end
		return CODE_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [CODE_W-1:0] want;
		item_t             req;
		if (!arst_n) begin
			period_q  = SCAN_PERIOD_RST;
			long_q    = LONG_TICKS_RST;
			tick_cnt  = '0;
			hold_cnt  = '0;
			prev_code = CODE_NONE;
			cur_code  = CODE_NONE;
			event_q   = CODE_NONE;
			expected_events.delete();
			errors = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCAN_PERIOD: period_q = cfg_data[DIV_W-1:0];
					CFG_LONG_TICKS:  long_q   = cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end
			// result transfer: compare with the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					if (errors < 10)
						$display("%0t: key_event %0d with no request pending", $realtime,
							key_event);
					errors++;
				end else begin
					want = expected_events.pop_front();
					if (key_event !== want) begin
						if (errors < 10)
							$display("%0t: key_event mismatch: expected %0d, got %0d",
								$realtime, want, key_event);
						errors++;
					end
				end
			end
			// request transfer: predict
			if (in_valid && in_ready) begin
				req = {req_type, key1_level, key2_level, key3_level};
				expected_events.push_back(scan_keys(req));
			end
			fail_count <= errors;
			pending    <= expected_events.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for key_scanner_long_press
// Drives ticks and reads with random gaps and result stalls, moves the scan
// period and long press threshold between phases, and reports the verdict
// from the checker's failure count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import kslp_pkg::*;

	localparam int       CYCLE_LIMIT = 1000000;
	localparam int       PHASE_ITEMS = 240;
	// key levels {key1, key2, key3}, low means pressed
	localparam logic [2:0] KEYS_UP = 3'b111;
	localparam logic [2:0] KEY1_DN = 3'b011;
	localparam logic [2:0] KEY2_DN = 3'b101;
	localparam logic [2:0] KEY3_DN = 3'b110;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  req_type;
	logic                  key1_level;
	logic                  key2_level;
	logic                  key3_level;
	logic                  out_valid;
	logic                  out_ready;
	logic [CODE_W-1:0]     key_event;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int item_count    = 0;
	int cycle_count   = 0;
	int cur_sp        = int'(SCAN_PERIOD_RST);
	int cur_lpt       = int'(LONG_TICKS_RST);

	always #5 clk = ~clk;

	key_scanner_long_press DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key1_level (key1_level),
		.key2_level (key2_level),
		.key3_level (key3_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_event  (key_event),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	key_event_checker event_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key1_level (key1_level),
		.key2_level (key2_level),
		.key3_level (key3_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_event  (key_event),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// one request transfer, with a random gap in front
	task automatic send_item(input logic rt, input logic [2:0] lv);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		req_type   <= rt;
		key1_level <= lv[2];
		key2_level <= lv[1];
		key3_level <= lv[0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		item_count++;
	endtask

	// wait until every predicted event has come back, then let the pipe settle
	task automatic drain_events();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	// both registers, written back to back while idle
	task automatic write_regs(input logic [DIV_W-1:0] sp, input logic [HOLD_W-1:0] lpt);
		logic [7:0] pad;
		pad       = 8'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCAN_PERIOD;
		cfg_data  <= {pad, sp};
		@(posedge clk);
		cfg_index <= CFG_LONG_TICKS;
		cfg_data  <= lpt;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_sp  = int'(sp);
		cur_lpt = int'(lpt);
	endtask

	// mostly press/hold/release/read sequences, some noise
	task automatic run_random(input int n);
		int         start;
		int         hold_len;
		int         rel_len;
		int         span;
		logic [2:0] lv;
		start = item_count;
		while (item_count - start < n) begin
			if ($urandom_range(99) < 75) begin
				case ($urandom_range(9))
					0, 1:       lv = KEY1_DN;
					2, 3:       lv = KEY2_DN;
					4, 5, 6, 7: lv = KEY3_DN;
					default:    lv = 3'($urandom_range(6));
				endcase
				span = cur_lpt + 2 * cur_sp + 4;
				if (span > 300)
					span = 300;
				hold_len = int'($urandom_range(span, 1));
				for (int i = 0; i < hold_len && item_count - start < n; i++) begin
					send_item(REQ_TICK, lv);
					if ($urandom_range(39) == 0)
						send_item(REQ_READ, 3'($urandom));
				end
				span = 2 * cur_sp + 2;
				if (span > 300)
					span = 300;
				rel_len = int'($urandom_range(span, 1));
				for (int i = 0; i < rel_len && item_count - start < n; i++)
					send_item(REQ_TICK, KEYS_UP);
				// skip some reads so newer releases overwrite
				if ($urandom_range(4) != 0)
					send_item(REQ_READ, 3'($urandom));
			end else begin
				repeat ($urandom_range(8, 1))
					send_item(($urandom_range(3) == 0) ? REQ_READ : REQ_TICK, 3'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int unsigned phase_sp[6];
		int unsigned phase_lpt[6];
		phase_sp   = '{1, 0, 2, 255, 5, 1};
		phase_lpt  = '{3, 0, 8, 100, 65535, 0};
		in_valid   <= 1'b0;
		req_type   <= REQ_TICK;
		key1_level <= 1'b1;
		key2_level <= 1'b1;
		key3_level <= 1'b1;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_SCAN_PERIOD;
		cfg_data   <= '0;
		out_ready  <= 1'b0;
		arst_n     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, nothing latched yet, levels ignored on reads
		send_idle_pct = 36;
		recv_idle_pct = 79;
		send_item(REQ_READ, 3'b000);
		send_item(REQ_READ, KEYS_UP);
		repeat (3) send_item(REQ_TICK, 3'b000);
		drain_events();

		write_regs(8'd1, 16'd2);
		// key 1, then key 2 beating key 3
		repeat (2) send_item(REQ_TICK, KEY1_DN);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_READ, 3'b000);
		send_item(REQ_TICK, 3'b100);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_READ, KEYS_UP);
		// key 3 short, then long
		repeat (2) send_item(REQ_TICK, KEY3_DN);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_READ, KEYS_UP);
		repeat (4) send_item(REQ_TICK, KEY3_DN);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_READ, KEYS_UP);
		// a newer release overwrites the unread one; second read is empty
		send_item(REQ_TICK, KEY1_DN);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_TICK, KEY2_DN);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_READ, KEYS_UP);
		send_item(REQ_READ, KEYS_UP);
		drain_events();

		// zero period samples every tick
		write_regs(8'd0, 16'd0);
		repeat (2) send_item(REQ_TICK, KEY3_DN);
		send_item(REQ_TICK, KEYS_UP);
		send_item(REQ_READ, KEYS_UP);
		drain_events();

		// random phases: receiver-heavy stalls, sender-heavy gaps, then full rate
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (p == 5)
				phase_lpt[p] = $urandom_range(20);
			write_regs(phase_sp[p][DIV_W-1:0], phase_lpt[p][HOLD_W-1:0]);
			run_random(PHASE_ITEMS);
			drain_events();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: key_scanner_long_press.f
+incdir+rtl
rtl/kslp_pkg.sv
rtl/kslp_in_reg.sv
rtl/kslp_engine.sv
rtl/key_scanner_long_press.sv
verif/key_event_checker.sv
verif/tb_top.sv
